// File: src/mca_pkg.sv
// ----------------------------------------------------------------------------
// mca_pkg: shared types and constants for the mixer channel allocator
// Request and result codes, field widths and parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package mca_pkg;

  localparam int CHANNELS_DEF   = 32;
  localparam int SLOT_COUNT_DEF = 16;

  // fixed field widths of the streaming items
  localparam int MODE_W   = 3;
  localparam int CHAN_W   = 6;
  localparam int SLOT_W   = 4;
  localparam int STATUS_W = 3;
  localparam int MASK_W   = 32;

  localparam logic [CHAN_W-1:0] CHAN_NONE = '1;

  typedef enum logic [MODE_W-1:0] {
    MODE_START    = 3'd0,
    MODE_REPLAY   = 3'd1,
    MODE_STOP     = 3'd2,
    MODE_ENDED    = 3'd3,
    MODE_STOP_ALL = 3'd4
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED  = 3'd0,
    ST_PLAYING  = 3'd1,
    ST_NOFREE   = 3'd2,
    ST_STOPPED  = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_RELEASED = 3'd5,
    ST_IGNORED  = 3'd6
  } status_t;

endpackage

`default_nettype wire

// File: src/mca_first_set.sv
// ----------------------------------------------------------------------------
// mca_first_set: lowest set bit finder
// Returns whether any bit is set, the index of the lowest one and a one-hot
// vector that isolates it.
// ----------------------------------------------------------------------------
`default_nettype none

module mca_first_set #(
  parameter int WIDTH = 32,
  parameter int IDX_W = 5
) (
  input  wire logic [WIDTH-1:0] req,
  output logic                  found,
  output logic [IDX_W-1:0]      idx,
  output logic [WIDTH-1:0]      first
);

  assign found = |req;
  assign first = req & (~req + WIDTH'(1));

  always_comb begin
    idx = '0;
    for (int i = WIDTH - 1; i >= 0; i--) begin
      if (req[i]) begin
        idx = IDX_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

// File: src/mixer_channel_allocator_core.sv
// ----------------------------------------------------------------------------
// mixer_channel_allocator_core: first-fit voice channel allocator
// Grants, stops and releases mixer channels from an in-use bitmap.
// ----------------------------------------------------------------------------
// Takes one request item per clock while no result is held back by out_tready
// low, and returns one result item for each. A request is latched into an
// input register, resolved by a single pass of combinational logic (release,
// lowest-free or lowest-free-pair search, owner match search) and written to
// the result register together with the new bitmap state, which drives
// out_tvalid. A result held by out_tready low keeps the request in the input
// register, and in_tready drops until the result is taken.
// Mono sounds take the lowest free channel, stereo sounds the lowest free
// adjacent pair. Owner slots of channels are undefined until first granted.
`default_nettype none

module mixer_channel_allocator_core
  import mca_pkg::*;
#(
  parameter int CHANNELS   = CHANNELS_DEF,
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [5:0] channel, [9:6] slot, [10] stereo, [11] sound_ready,
  // [12] still_playing, [15:13] zero
  input  wire logic [15:0] in_tdata,
  // [2:0] mode
  input  wire logic [2:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [5:0] result_channel, [37:6] stop_mask, [69:38] in_use_mask, [71:70] zero
  output logic [71:0]      out_tdata,
  // [2:0] status
  output logic [2:0]       out_tuser
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CHAN_W-1:0] CHAN_LIM = CHAN_W'(CHANNELS);
  localparam int SL_W = (SLOT_W > $clog2(SLOT_COUNT + 1)) ? SLOT_W
                                                          : $clog2(SLOT_COUNT + 1);
  localparam logic [SL_W-1:0] SLOT_LIM = SL_W'(SLOT_COUNT);

  // input register
  logic                s1_vld_r;
  logic [MODE_W-1:0]   mode_r;
  logic [CHAN_W-1:0]   chan_r;
  logic [SLOT_W-1:0]   slot_r;
  logic                stereo_r;
  logic                ready_r;
  logic                playing_r;

  // allocator state
  logic [CHANNELS-1:0] in_use_r, in_use_nxt;
  logic [CHANNELS-1:0] sp_r, sp_nxt;
  logic [SLOT_W-1:0]   owner_r [CHANNELS];
  logic [CHANNELS-1:0] own_we;

  // result register
  logic                out_vld_r;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [CHAN_W-1:0]   res_r, res_nxt;
  logic [CHANNELS-1:0] stop_r, stop_nxt;
  logic [CHANNELS-1:0] use_out_r;

  logic advance;

  assign advance   = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || advance;

  // ---------------------------------------------------------------- decode
  logic [CH_W-1:0]     ch_idx;
  logic                ch_valid;
  logic [CHANNELS-1:0] ch_oh;
  logic                ch_used;
  logic                owner_hit;
  logic                slot_ok;
  logic [CHANNELS-1:0] sub_mark;

  assign ch_idx   = chan_r[CH_W-1:0];
  assign ch_valid = !chan_r[CHAN_W-1] && (chan_r < CHAN_LIM);

  always_comb begin
    ch_oh = '0;
    if (ch_valid) begin
      ch_oh[ch_idx] = 1'b1;
    end
  end

  assign ch_used   = |(ch_oh & in_use_r);
  assign owner_hit = ch_used && (owner_r[ch_idx] == slot_r);
  assign slot_ok   = ready_r && (SL_W'(slot_r) < SLOT_LIM);
  // bit c set when channel c-1 is a stereo primary, i.e. c is a sub-channel
  assign sub_mark  = {sp_r[CHANNELS-2:0], 1'b0};

  function automatic logic [CHANNELS-1:0] rel_clear(
    input logic [CHANNELS-1:0] oh,
    input logic [CHANNELS-1:0] sp
  );
    logic [CHANNELS-1:0] pri;
    pri = oh & sp;
    return oh | {pri[CHANNELS-2:0], 1'b0};
  endfunction

  // ------------------------------------------------ replay release + grant
  logic [CHANNELS-1:0] rp_oh;
  logic [CHANNELS-1:0] g_use;
  logic [CHANNELS-1:0] g_sp;
  logic [CHANNELS-1:0] free_v;
  logic [CHANNELS-2:0] pair_free;

  assign rp_oh     = (mode_r == MODE_REPLAY && ch_used) ? ch_oh : '0;
  assign g_use     = in_use_r & ~rel_clear(rp_oh, sp_r);
  assign g_sp      = sp_r & ~rp_oh;
  assign free_v    = ~g_use;
  assign pair_free = free_v[CHANNELS-2:0] & free_v[CHANNELS-1:1];

  logic                mono_found;
  logic [CH_W-1:0]     mono_idx;
  logic [CHANNELS-1:0] mono_first;
  logic                pair_found;
  logic [CH_W-1:0]     pair_idx;
  logic [CHANNELS-2:0] pair_first;

  mca_first_set #(.WIDTH(CHANNELS), .IDX_W(CH_W)) u_mono (
    .req   (free_v),
    .found (mono_found),
    .idx   (mono_idx),
    .first (mono_first)
  );

  mca_first_set #(.WIDTH(CHANNELS - 1), .IDX_W(CH_W)) u_pair (
    .req   (pair_free),
    .found (pair_found),
    .idx   (pair_idx),
    .first (pair_first)
  );

  // --------------------------------------------------- owner match search
  logic [CHANNELS-1:0] match_v;
  logic                match_found;
  logic [CH_W-1:0]     match_idx;
  logic [CHANNELS-1:0] match_first;

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      match_v[i] = in_use_r[i] && (owner_r[i] == slot_r);
    end
  end

  mca_first_set #(.WIDTH(CHANNELS), .IDX_W(CH_W)) u_match (
    .req   (match_v),
    .found (match_found),
    .idx   (match_idx),
    .first (match_first)
  );

  // ------------------------------------------------------- request resolve
  always_comb begin
    logic [CHANNELS-1:0] gbits;
    logic [CHANNELS-1:0] tgt;

    in_use_nxt = in_use_r;
    sp_nxt     = sp_r;
    status_nxt = ST_IGNORED;
    res_nxt    = CHAN_NONE;
    stop_nxt   = '0;
    own_we     = '0;
    gbits      = '0;
    tgt        = '0;

    case (mode_r)
      MODE_START, MODE_REPLAY: begin
        if (slot_ok) begin
          if (mode_r == MODE_START && owner_hit && playing_r) begin
            status_nxt = ST_PLAYING;
            res_nxt    = chan_r;
          end else begin
            stop_nxt   = rp_oh;
            in_use_nxt = g_use;
            sp_nxt     = g_sp;
            status_nxt = ST_NOFREE;
            if (stereo_r) begin
              if (pair_found) begin
                gbits      = {pair_first, 1'b0} | {1'b0, pair_first};
                sp_nxt     = g_sp | {1'b0, pair_first};
                status_nxt = ST_GRANTED;
                res_nxt    = CHAN_W'(pair_idx);
              end
            end else if (mono_found) begin
              gbits      = mono_first;
              sp_nxt     = g_sp & ~mono_first;
              status_nxt = ST_GRANTED;
              res_nxt    = CHAN_W'(mono_idx);
            end
            in_use_nxt = g_use | gbits;
            own_we     = gbits;
          end
        end
      end
      MODE_STOP: begin
        if (owner_hit) begin
          tgt     = ch_oh;
          res_nxt = chan_r;
        end else begin
          tgt     = match_first;
          res_nxt = match_found ? CHAN_W'(match_idx) : CHAN_NONE;
        end
        if (owner_hit || match_found) begin
          stop_nxt   = tgt;
          in_use_nxt = in_use_r & ~rel_clear(tgt, sp_r);
          sp_nxt     = sp_r & ~tgt;
          status_nxt = ST_STOPPED;
        end else begin
          status_nxt = ST_NOTFOUND;
        end
      end
      MODE_ENDED: begin
        if (ch_used && !(|(ch_oh & sub_mark))) begin
          in_use_nxt = in_use_r & ~rel_clear(ch_oh, sp_r);
          sp_nxt     = sp_r & ~ch_oh;
          status_nxt = ST_RELEASED;
          res_nxt    = chan_r;
        end
      end
      MODE_STOP_ALL: begin
        stop_nxt   = in_use_r;
        in_use_nxt = '0;
        sp_nxt     = '0;
        status_nxt = ST_STOPPED;
      end
      default: begin
      end
    endcase
  end

  // -------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      in_use_r  <= '0;
      sp_r      <= '0;
    end else begin
      if (in_tready) begin
        s1_vld_r <= in_tvalid;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
        in_use_r  <= in_use_nxt;
        sp_r      <= sp_nxt;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      mode_r    <= in_tuser;
      chan_r    <= in_tdata[5:0];
      slot_r    <= in_tdata[9:6];
      stereo_r  <= in_tdata[10];
      ready_r   <= in_tdata[11];
      playing_r <= in_tdata[12];
    end
    if (advance) begin
      status_r  <= status_nxt;
      res_r     <= res_nxt;
      stop_r    <= stop_nxt;
      use_out_r <= in_use_nxt;
    end
  end

  // owner slot per channel, written on grant only
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (own_we[i]) begin
          owner_r[i] <= slot_r;
        end
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {2'b00, MASK_W'(use_out_r), MASK_W'(stop_r), res_r};

endmodule

`default_nettype wire

// File: test/tb_mixer_channel_allocator_core.sv
// ----------------------------------------------------------------------------
// tb_mixer_channel_allocator_core: self-checking bench for the channel allocator
// Drives request items on the input stream and checks every result item. The
// expected values come from a behavioral model of the in-use and stereo pair
// bitmaps, or from the fixed table rows. A directed table runs first, then random
// traffic biased to fill or drain; early phases stall source and sink at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_mixer_channel_allocator_core;
  import mca_pkg::*;

  localparam int NCH            = CHANNELS_DEF;
  localparam int DIR_ROWS       = 25;
  localparam int RAND_PER_PHASE = 390;
  localparam int QUIET_LIMIT    = 2000;
  localparam int TAIL_CYCLES    = 10;

  // modes the block must ignore
  localparam logic [MODE_W-1:0] MODE_RSVD5 = 3'd5;
  localparam logic [MODE_W-1:0] MODE_RSVD7 = 3'd7;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CHAN_W-1:0] channel;
    logic [SLOT_W-1:0] slot;
    logic              stereo;
    logic              ready;
    logic              playing;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [CHAN_W-1:0] chan;
    logic [MASK_W-1:0] stop_mask;
    logic [MASK_W-1:0] busy_mask;
  } res_t;

  typedef struct packed {
    req_t req;
    logic fixed;
    res_t res;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic [2:0]  out_tuser;

  // typed expectation that travels with the item on the bus
  logic item_fixed = 1'b0;
  res_t item_fixed_res = '0;

  // allocator model state
  logic [NCH-1:0] chan_busy = '0;
  logic [NCH-1:0] chan_pair_head = '0;
  logic [3:0]     chan_owner [NCH];

  // copy of the model state taken at the falling edge, used to steer stimulus
  logic [NCH-1:0] busy_view = '0;
  logic [3:0]     owner_view [NCH];

  res_t     alloc_results_due [$];
  dir_row_t dir_rows [DIR_ROWS];
  int       errors = 0;
  int       items_sent = 0;
  int       results_seen = 0;
  int       quiet_cycles = 0;
  int       status_count [7];
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  logic     fill_bias = 1'b1;

  mixer_channel_allocator_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(negedge clk) begin
    busy_view <= chan_busy;
    for (int i = 0; i < NCH; i++) owner_view[i] <= chan_owner[i];
  end

  task automatic report(input string msg);
    errors++;
    $display("MISMATCH: %s", msg);
  endtask

  function automatic int lowest_free_chan();
    for (int i = 0; i < NCH; i++)
      if (!chan_busy[i]) return i;
    return -1;
  endfunction

  function automatic int lowest_free_pair();
    for (int i = 0; i + 1 < NCH; i++)
      if (!chan_busy[i] && !chan_busy[i+1]) return i;
    return -1;
  endfunction

  // release a channel, and its partner when it heads a stereo pair
  task automatic free_chan(input int c);
    chan_busy[c] = 1'b0;
    if (chan_pair_head[c]) begin
      chan_pair_head[c] = 1'b0;
      if (c + 1 < NCH) chan_busy[c+1] = 1'b0;
    end
  endtask

  task automatic resolve_request(input req_t r, output res_t o);
    int   ch;
    int   c;
    logic valid;
    ch = $signed(r.channel);
    valid = (ch >= 0) && (ch < NCH);
    o.status = ST_IGNORED;
    o.chan = CHAN_NONE;
    o.stop_mask = '0;
    case (r.mode)
      MODE_START, MODE_REPLAY: begin
        if (r.ready) begin
          if (r.mode == MODE_START && valid && chan_busy[ch] &&
              chan_owner[ch] == r.slot && r.playing) begin
            o.status = ST_PLAYING;
            o.chan = r.channel;
          end else begin
            if (r.mode == MODE_REPLAY && valid && chan_busy[ch]) begin
              o.stop_mask[ch] = 1'b1;
              free_chan(ch);
            end
            c = r.stereo ? lowest_free_pair() : lowest_free_chan();
            if (c < 0) begin
              o.status = ST_NOFREE;
            end else begin
              chan_busy[c] = 1'b1;
              chan_owner[c] = r.slot;
              if (r.stereo) begin
                chan_pair_head[c] = 1'b1;
                chan_busy[c+1] = 1'b1;
                chan_owner[c+1] = r.slot;
              end else begin
                chan_pair_head[c] = 1'b0;
              end
              o.status = ST_GRANTED;
              o.chan = c[CHAN_W-1:0];
            end
          end
        end
      end
      MODE_STOP: begin
        c = -1;
        if (valid && chan_busy[ch] && chan_owner[ch] == r.slot) begin
          c = ch;
        end else begin
          for (int i = NCH - 1; i >= 0; i--)
            if (chan_busy[i] && chan_owner[i] == r.slot) c = i;
        end
        if (c >= 0) begin
          o.stop_mask[c] = 1'b1;
          free_chan(c);
          o.status = ST_STOPPED;
          o.chan = c[CHAN_W-1:0];
        end else begin
          o.status = ST_NOTFOUND;
        end
      end
      MODE_ENDED: begin
        if (valid && chan_busy[ch]) begin
          // a stereo sub-channel ending is left to its primary
          if (!(ch > 0 && chan_pair_head[ch-1])) begin
            free_chan(ch);
            o.status = ST_RELEASED;
            o.chan = r.channel;
          end
        end
      end
      MODE_STOP_ALL: begin
        o.stop_mask = chan_busy;
        chan_busy = '0;
        chan_pair_head = '0;
        o.status = ST_STOPPED;
      end
      default: ;
    endcase
    o.busy_mask = chan_busy;
  endtask

  // result check, expectation bookkeeping and watchdog
  always @(posedge clk) begin
    res_t got;
    res_t want;
    req_t acc;
    logic moved;
    moved = 1'b0;
    if (rst_n && out_tvalid && out_tready) begin
      moved = 1'b1;
      results_seen++;
      got.status = status_t'(out_tuser);
      got.chan = out_tdata[5:0];
      got.stop_mask = out_tdata[37:6];
      got.busy_mask = out_tdata[69:38];
      if (alloc_results_due.size() == 0) begin
        report($sformatf("result with nothing expected: status %0d channel %0d",
                         got.status, $signed(got.chan)));
      end else begin
        want = alloc_results_due.pop_front();
        status_count[want.status]++;
        if (got.status !== want.status)
          report($sformatf("status got %0d want %0d", got.status, want.status));
        if (got.chan !== want.chan)
          report($sformatf("result_channel got %0d want %0d",
                           $signed(got.chan), $signed(want.chan)));
        if (got.stop_mask !== want.stop_mask)
          report($sformatf("stop_mask got %h want %h", got.stop_mask, want.stop_mask));
        if (got.busy_mask !== want.busy_mask)
          report($sformatf("in_use_mask got %h want %h", got.busy_mask, want.busy_mask));
      end
    end
    if (rst_n && in_tvalid && in_tready) begin
      moved = 1'b1;
      acc.mode = in_tuser;
      acc.channel = in_tdata[5:0];
      acc.slot = in_tdata[9:6];
      acc.stereo = in_tdata[10];
      acc.ready = in_tdata[11];
      acc.playing = in_tdata[12];
      resolve_request(acc, want);
      alloc_results_due.push_back(item_fixed ? item_fixed_res : want);
    end
    if (moved) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic dir_row_t row(input logic [MODE_W-1:0] mode, input int ch,
                                   input int slot, input logic st, input logic rd,
                                   input logic pl, input logic fixed, input status_t s,
                                   input int rc, input logic [31:0] stop,
                                   input logic [31:0] busy);
    dir_row_t d;
    d.req.mode = mode;
    d.req.channel = ch[CHAN_W-1:0];
    d.req.slot = slot[SLOT_W-1:0];
    d.req.stereo = st;
    d.req.ready = rd;
    d.req.playing = pl;
    d.fixed = fixed;
    d.res.status = s;
    d.res.chan = rc[CHAN_W-1:0];
    d.res.stop_mask = stop;
    d.res.busy_mask = busy;
    return d;
  endfunction

  task automatic drive_item(input req_t r, input logic fixed, input res_t fixed_res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= r.mode;
    in_tdata <= {3'b000, r.playing, r.ready, r.stereo, r.slot, r.channel};
    item_fixed <= fixed;
    item_fixed_res <= fixed_res;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // hold the source off until every outstanding result has come back
  task automatic wait_results_home();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (alloc_results_due.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic random_request(output req_t r);
    int pick;
    int c;
    int tmp;
    pick = $urandom_range(99);
    if (fill_bias) begin
      if (pick < 60)      r.mode = MODE_START;
      else if (pick < 75) r.mode = MODE_REPLAY;
      else if (pick < 85) r.mode = MODE_STOP;
      else if (pick < 97) r.mode = MODE_ENDED;
      else if (pick < 98) r.mode = MODE_STOP_ALL;
      else begin
        tmp = $urandom_range(7, 5);
        r.mode = tmp[MODE_W-1:0];
      end
    end else begin
      if (pick < 15)      r.mode = MODE_START;
      else if (pick < 25) r.mode = MODE_REPLAY;
      else if (pick < 55) r.mode = MODE_STOP;
      else if (pick < 95) r.mode = MODE_ENDED;
      else if (pick < 98) r.mode = MODE_STOP_ALL;
      else begin
        tmp = $urandom_range(7, 5);
        r.mode = tmp[MODE_W-1:0];
      end
    end
    // the caller mostly names a channel that is really in use
    pick = $urandom_range(99);
    if (pick < 70 && busy_view != '0) begin
      c = $urandom_range(NCH - 1);
      while (!busy_view[c]) c = (c + 1) % NCH;
    end else if (pick < 85) begin
      c = -1;
    end else begin
      c = $urandom_range(63);
      c = c - 32;
    end
    r.channel = c[CHAN_W-1:0];
    tmp = $urandom_range(15);
    r.slot = tmp[SLOT_W-1:0];
    if (c >= 0) begin
      if (busy_view[c] && $urandom_range(99) < 60) r.slot = owner_view[c];
    end
    r.stereo = ($urandom_range(99) < 40);
    r.ready = ($urandom_range(99) < 92);
    r.playing = ($urandom_range(99) < 70);
  endtask

  initial begin
    req_t r;
    res_t no_res;
    no_res = '0;
    for (int i = 0; i < 7; i++) status_count[i] = 0;

    //                mode           ch slot st rd pl  fx  status       rc  stop   in_use
    dir_rows[0]  = row(MODE_ENDED,     0,  0, 0, 0, 0, 1, ST_IGNORED,  -1, 32'h0, 32'h0);
    dir_rows[1]  = row(MODE_STOP,     -1,  3, 0, 0, 0, 1, ST_NOTFOUND, -1, 32'h0, 32'h0);
    dir_rows[2]  = row(MODE_START,    -1,  1, 0, 0, 0, 1, ST_IGNORED,  -1, 32'h0, 32'h0);
    dir_rows[3]  = row(MODE_REPLAY,   -1,  1, 0, 0, 0, 1, ST_IGNORED,  -1, 32'h0, 32'h0);
    dir_rows[4]  = row(MODE_START,    -1,  0, 0, 1, 0, 1, ST_GRANTED,   0, 32'h0, 32'h1);
    dir_rows[5]  = row(MODE_START,    -1, 15, 1, 1, 0, 1, ST_GRANTED,   1, 32'h0, 32'h7);
    dir_rows[6]  = row(MODE_START,     1, 15, 1, 1, 1, 1, ST_PLAYING,   1, 32'h0, 32'h7);
    dir_rows[7]  = row(MODE_START,     1, 15, 1, 1, 0, 0, ST_IGNORED,  -1, 32'h0, 32'h0);
    dir_rows[8]  = row(MODE_START,     0, 15, 0, 1, 1, 0, ST_IGNORED,  -1, 32'h0, 32'h0);
    dir_rows[9]  = row(MODE_ENDED,     2,  0, 0, 0, 0, 0, ST_IGNORED,  -1, 32'h0, 32'h0);
    dir_rows[10] = row(MODE_ENDED,     4,  0, 0, 1, 1, 0, ST_IGNORED,  -1, 32'h0, 32'h0);
    dir_rows[11] = row(MODE_ENDED,    -1,  0, 0, 0, 0, 0, ST_IGNORED,  -1, 32'h0, 32'h0);
    dir_rows[12] = row(MODE_ENDED,     3,  0, 0, 0, 1, 0, ST_IGNORED,  -1, 32'h0, 32'h0);
    dir_rows[13] = row(MODE_REPLAY,    1,  7, 0, 1, 0, 0, ST_IGNORED,  -1, 32'h0, 32'h0);
    dir_rows[14] = row(MODE_STOP,     31,  0, 0, 0, 0, 0, ST_IGNORED,  -1, 32'h0, 32'h0);
    dir_rows[15] = row(MODE_STOP,      5, 15, 1, 1, 1, 0, ST_IGNORED,  -1, 32'h0, 32'h0);
    dir_rows[16] = row(MODE_RSVD5,     1,  7, 0, 1, 1, 0, ST_IGNORED,  -1, 32'h0, 32'h0);
    dir_rows[17] = row(MODE_RSVD7,   -32,  0, 1, 1, 0, 0, ST_IGNORED,  -1, 32'h0, 32'h0);
    dir_rows[18] = row(MODE_STOP_ALL,  0,  0, 0, 0, 0, 0, ST_IGNORED,  -1, 32'h0, 32'h0);
    dir_rows[19] = row(MODE_STOP_ALL, -1, 15, 1, 1, 1, 1, ST_STOPPED,  -1, 32'h0, 32'h0);
    dir_rows[20] = row(MODE_START,   -32,  9, 1, 1, 0, 1, ST_GRANTED,   0, 32'h0, 32'h3);
    dir_rows[21] = row(MODE_REPLAY,    0,  9, 1, 1, 1, 0, ST_IGNORED,  -1, 32'h0, 32'h0);
    dir_rows[22] = row(MODE_ENDED,     0,  0, 0, 0, 0, 0, ST_IGNORED,  -1, 32'h0, 32'h0);
    dir_rows[23] = row(MODE_ENDED,    31, 15, 1, 1, 1, 0, ST_IGNORED,  -1, 32'h0, 32'h0);
    dir_rows[24] = row(MODE_START,    31, 15, 0, 1, 1, 1, ST_GRANTED,   0, 32'h0, 32'h1);

    send_idle_pct = 36;
    recv_idle_pct = 81;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++)
      drive_item(dir_rows[i].req, dir_rows[i].fixed, dir_rows[i].res);

    for (int phase = 0; phase < 3; phase++) begin
      if (phase > 0) begin
        wait_results_home();
        send_idle_pct = (phase == 1) ? 81 : 0;
        recv_idle_pct = (phase == 1) ? 36 : 0;
      end
      for (int k = 0; k < RAND_PER_PHASE; k++) begin
        if (k % 60 == 0) fill_bias = ($urandom_range(1) == 1);
        if ($urandom_range(149) == 0) wait_results_home();
        random_request(r);
        drive_item(r, 1'b0, no_res);
      end
    end

    wait_results_home();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d request items sent, %0d result items checked, %0d mismatches",
             items_sent, results_seen, errors);
    $display("granted %0d, playing %0d, no free %0d, stopped %0d, not found %0d, %s %0d, %s %0d",
             status_count[ST_GRANTED], status_count[ST_PLAYING], status_count[ST_NOFREE],
             status_count[ST_STOPPED], status_count[ST_NOTFOUND],
             "released", status_count[ST_RELEASED], "ignored", status_count[ST_IGNORED]);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
